// ----- hw/rtl/vest_pkg.sv -----
// Shared constants for the velocity estimator with stationary trigger.
`default_nettype none

package vest_pkg;

  // Serial multiply by the microseconds-per-second constant.
  localparam int MulBits = 20;
  localparam logic [MulBits-1:0] MicroPerSec = 20'd1000000;

  // Dividend of the serial divider: a 32-bit delta magnitude times MicroPerSec.
  localparam int DivBits = 32 + MulBits;

  // Steps of the serial squaring unit, one per bit of a velocity magnitude.
  localparam int SqrBits = 32;

  // Step counters of the serial units.
  localparam int CntW = 6;

  // Packed stream widths, rounded up to whole bytes.
  localparam int SDataW = 168;
  localparam int MDataW = 200;

  // Configuration register indexes.
  localparam logic [1:0] CfgFallback = 2'd0;
  localparam logic [1:0] CfgSpeedLim = 2'd1;
  localparam logic [1:0] CfgStillCnt = 2'd2;

  // Configuration reset values.
  localparam logic [31:0] FallbackRst = 32'd10000;
  localparam logic [30:0] SpeedLimRst = 31'd6554;
  localparam logic [15:0] StillCntRst = 16'd200;

  // Input transaction kinds carried in tuser.
  localparam logic OpSample  = 1'b0;
  localparam logic OpCollect = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/vest_axis.sv -----
// Per-axis velocity unit: serial multiply by 1e6, bit-serial divide, saturate.
`default_nettype none

module vest_axis
  import vest_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] now_i,
  input  wire logic [31:0] prev_i,
  input  wire logic [31:0] dt_i,
  output logic             done_o,
  output logic [31:0]      vel_o
);

  typedef enum logic [3:0] {
    AX_IDLE = 4'b0001,
    AX_MUL  = 4'b0010,
    AX_DIV  = 4'b0100,
    AX_SAT  = 4'b1000
  } ax_state_e;

  ax_state_e           state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [31:0]         mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [DivBits-1:0]  acc_q, acc_d;
  logic [31:0]         rem_q, rem_d;
  logic [31:0]         dt_q, dt_d;
  logic [31:0]         vel_q, vel_d;

  logic [32:0]         delta;
  logic [32:0]         mag_full;
  logic [4:0]          mul_idx;
  logic [32:0]         r_sh;
  logic [32:0]         r_diff;
  logic                r_ge;
  logic [31:0]         sat;

  assign delta    = {now_i[31], now_i} - {prev_i[31], prev_i};
  assign mag_full = delta[32] ? (33'd0 - delta) : delta;
  assign mul_idx  = 5'(MulBits - 1) - cnt_q[4:0];
  assign r_sh     = {rem_q, acc_q[DivBits-1]};
  assign r_diff   = r_sh - {1'b0, dt_q};
  assign r_ge     = r_sh >= {1'b0, dt_q};

  // Truncated quotient magnitude to a saturated two's complement value.
  always_comb begin
    if (!neg_q) begin
      if (acc_q[DivBits-1:31] != '0) begin
        sat = 32'h7FFF_FFFF;
      end else begin
        sat = {1'b0, acc_q[30:0]};
      end
    end else begin
      if ((acc_q[DivBits-1:32] != '0) || (acc_q[31] && (acc_q[30:0] != '0))) begin
        sat = 32'h8000_0000;
      end else begin
        sat = 32'd0 - acc_q[31:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    mag_d   = mag_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dt_d    = dt_q;
    vel_d   = vel_q;
    unique case (state_q)
      AX_IDLE: begin
        if (start_i) begin
          mag_d   = mag_full[31:0];
          neg_d   = delta[32];
          dt_d    = dt_i;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = AX_MUL;
        end
      end
      AX_MUL: begin
        acc_d = {acc_q[DivBits-2:0], 1'b0}
              + (MicroPerSec[mul_idx] ? {{(DivBits-32){1'b0}}, mag_q} : '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(MulBits - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = AX_DIV;
        end
      end
      AX_DIV: begin
        rem_d = r_ge ? r_diff[31:0] : r_sh[31:0];
        acc_d = {acc_q[DivBits-2:0], r_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivBits - 1)) begin
          state_d = AX_SAT;
        end
      end
      AX_SAT: begin
        vel_d   = sat;
        done_d  = 1'b1;
        state_d = AX_IDLE;
      end
      default: begin
        state_d = AX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AX_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    dt_q  <= dt_d;
    vel_q <= vel_d;
  end

  assign done_o = done_q;
  assign vel_o  = vel_q;

endmodule

`default_nettype wire

// ----- hw/rtl/vest_sqr.sv -----
// Serial squared-speed unit: sum of squared velocities against the squared limit.
`default_nettype none

module vest_sqr
  import vest_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] vel_x_i,
  input  wire logic [31:0] vel_y_i,
  input  wire logic [30:0] limit_i,
  output logic             done_o,
  output logic             slow_o
);

  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_RUN  = 3'b010,
    SQ_CMP  = 3'b100
  } sq_state_e;

  sq_state_e         state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              slow_q, slow_d;
  logic [31:0]       mx_q, mx_d, my_q, my_d, ml_q, ml_d;
  logic [31:0]       sx_q, sx_d, sy_q, sy_d, sl_q, sl_d;
  logic [63:0]       acc_q, acc_d, lim_q, lim_d;

  logic [31:0]       abs_x, abs_y;

  assign abs_x = vel_x_i[31] ? (32'd0 - vel_x_i) : vel_x_i;
  assign abs_y = vel_y_i[31] ? (32'd0 - vel_y_i) : vel_y_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    slow_d  = slow_q;
    mx_d = mx_q; my_d = my_q; ml_d = ml_q;
    sx_d = sx_q; sy_d = sy_q; sl_d = sl_q;
    acc_d = acc_q;
    lim_d = lim_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          mx_d = abs_x;
          my_d = abs_y;
          ml_d = {1'b0, limit_i};
          sx_d = abs_x;
          sy_d = abs_y;
          sl_d = {1'b0, limit_i};
          acc_d = '0;
          lim_d = '0;
          cnt_d = '0;
          state_d = SQ_RUN;
        end
      end
      SQ_RUN: begin
        // Multiplier bits enter from the top of each shift register.
        acc_d = {acc_q[62:0], 1'b0}
              + (sx_q[31] ? {32'd0, mx_q} : 64'd0)
              + (sy_q[31] ? {32'd0, my_q} : 64'd0);
        lim_d = {lim_q[62:0], 1'b0} + (sl_q[31] ? {32'd0, ml_q} : 64'd0);
        sx_d  = {sx_q[30:0], 1'b0};
        sy_d  = {sy_q[30:0], 1'b0};
        sl_d  = {sl_q[30:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrBits - 1)) begin
          state_d = SQ_CMP;
        end
      end
      SQ_CMP: begin
        slow_d  = acc_q < lim_q;
        done_d  = 1'b1;
        state_d = SQ_IDLE;
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slow_q <= slow_d;
    mx_q <= mx_d; my_q <= my_d; ml_q <= ml_d;
    sx_q <= sx_d; sy_q <= sy_d; sl_q <= sl_d;
    acc_q <= acc_d;
    lim_q <= lim_d;
  end

  assign done_o = done_q;
  assign slow_o = slow_q;

endmodule

`default_nettype wire

// ----- hw/rtl/velocity_estimator_stationary_trigger_unit.sv -----
// Top level of the velocity estimator with stationary trigger.
`default_nettype none

// Channel   Direction  Transaction carries
// s_axis    in         one position sample or one collect-finished notice
// m_axis    out        position, velocity and an optional collect goal
// cfg       in         one register write, no handshake
//
// A sample that yields a result passes from acceptance to the output register
// through 20 multiply steps and 52 divide steps in the per-axis serial units,
// 32 steps in the serial squaring unit, then saturate, compare, final update.
// A collect-finished notice or the first sample after reset yields no result.
// Reset clears all control state and loads the register reset values.
// A result waiting in the output register does not block a new sample; the
// block stalls only at the final update if that register is still occupied.

module velocity_estimator_stationary_trigger_unit
  import vest_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: pos_x[31:0], pos_y[31:0], stamp[31:0], world_x[31:0],
  // world_y[31:0], goal_ok, then zero fill.
  input  wire logic [SDataW-1:0] s_axis_tdata,
  // Fields from bit 0: op.
  input  wire logic [0:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // Fields from bit 0: out_x[31:0], out_y[31:0], vel_x[31:0], vel_y[31:0],
  // start_collect, goal_x[31:0], goal_y[31:0], then zero fill.
  output logic [MDataW-1:0]      m_axis_tdata,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_VEL  = 4'b0010,
    ST_SQR  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e       state_q, state_d;

  // Configuration registers.
  logic [31:0]  fallback_q;
  logic [30:0]  speed_lim_q;
  logic [15:0]  still_cnt_q;

  // Estimator state.
  logic         primed_q;
  logic         busy_q;
  logic [15:0]  slow_cnt_q;
  logic [31:0]  last_x_q, last_y_q, last_stamp_q;

  // Fields of the sample being worked on.
  logic [31:0]  cur_x_q, cur_y_q, world_x_q, world_y_q;
  logic         goal_ok_q;

  // Output register.
  logic         m_valid_q;
  logic [31:0]  o_x_q, o_y_q, o_vx_q, o_vy_q, o_gx_q, o_gy_q;
  logic         o_start_q;

  // Unpacked input fields.
  logic         in_op;
  logic [31:0]  in_pos_x, in_pos_y, in_stamp, in_world_x, in_world_y;
  logic         in_goal_ok;

  assign in_op      = s_axis_tuser[0];
  assign in_pos_x   = s_axis_tdata[31:0];
  assign in_pos_y   = s_axis_tdata[63:32];
  assign in_stamp   = s_axis_tdata[95:64];
  assign in_world_x = s_axis_tdata[127:96];
  assign in_world_y = s_axis_tdata[159:128];
  assign in_goal_ok = s_axis_tdata[160];

  logic         s_acc;
  logic         ax_start;
  logic [31:0]  stamp_diff;
  logic [31:0]  dt;
  logic         ax_done_x, ax_done_y;
  logic [31:0]  vel_x, vel_y;
  logic         sq_done, sq_slow;
  logic         fin_load;
  logic [15:0]  slow_nx;
  logic         trig, fire;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign ax_start      = s_acc && (in_op == OpSample) && primed_q;

  // An interval of one microsecond or less, including a stamp that went
  // backward, is replaced by the fallback; a zero fallback acts as one.
  assign stamp_diff = in_stamp - last_stamp_q;
  always_comb begin
    if ($signed(stamp_diff) < 32'sd2) begin
      dt = (fallback_q == '0) ? 32'd1 : fallback_q;
    end else begin
      dt = stamp_diff;
    end
  end

  vest_axis u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ax_start),
    .now_i  (in_pos_x),
    .prev_i (last_x_q),
    .dt_i   (dt),
    .done_o (ax_done_x),
    .vel_o  (vel_x)
  );

  vest_axis u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ax_start),
    .now_i  (in_pos_y),
    .prev_i (last_y_q),
    .dt_i   (dt),
    .done_o (ax_done_y),
    .vel_o  (vel_y)
  );

  vest_sqr u_sqr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ax_done_x && ax_done_y),
    .vel_x_i(vel_x),
    .vel_y_i(vel_y),
    .limit_i(speed_lim_q),
    .done_o (sq_done),
    .slow_o (sq_slow)
  );

  // The final update happens once the output register is free or emptying.
  assign fin_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  // Slow-sample run length, saturating at its full count.
  always_comb begin
    if (sq_slow) begin
      slow_nx = (slow_cnt_q == 16'hFFFF) ? slow_cnt_q : slow_cnt_q + 16'd1;
    end else begin
      slow_nx = '0;
    end
  end
  assign trig = !busy_q && (slow_nx >= still_cnt_q);
  assign fire = trig && goal_ok_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (ax_start) state_d = ST_VEL;
      ST_VEL:  if (ax_done_x && ax_done_y) state_d = ST_SQR;
      ST_SQR:  if (sq_done) state_d = ST_FIN;
      ST_FIN:  if (fin_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fallback_q   <= FallbackRst;
      speed_lim_q  <= SpeedLimRst;
      still_cnt_q  <= StillCntRst;
      primed_q     <= 1'b0;
      busy_q       <= 1'b0;
      slow_cnt_q   <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_stamp_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFallback: fallback_q  <= cfg_wdata_i;
          CfgSpeedLim: speed_lim_q <= cfg_wdata_i[30:0];
          CfgStillCnt: still_cnt_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      if (s_acc) begin
        if (in_op == OpCollect) begin
          busy_q <= 1'b0;
        end else begin
          // The first sample only primes; later ones also start the units.
          primed_q     <= 1'b1;
          last_x_q     <= in_pos_x;
          last_y_q     <= in_pos_y;
          last_stamp_q <= in_stamp;
        end
      end

      if (fin_load) begin
        slow_cnt_q <= trig ? 16'd0 : slow_nx;
        if (fire) begin
          busy_q <= 1'b1;
        end
      end

      if (fin_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ax_start) begin
      cur_x_q   <= in_pos_x;
      cur_y_q   <= in_pos_y;
      world_x_q <= in_world_x;
      world_y_q <= in_world_y;
      goal_ok_q <= in_goal_ok;
    end
    if (fin_load) begin
      o_x_q     <= cur_x_q;
      o_y_q     <= cur_y_q;
      o_vx_q    <= vel_x;
      o_vy_q    <= vel_y;
      o_start_q <= fire;
      o_gx_q    <= fire ? world_x_q : 32'd0;
      o_gy_q    <= fire ? world_y_q : 32'd0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, o_gy_q, o_gx_q, o_start_q, o_vy_q, o_vx_q, o_y_q, o_x_q};

  // Both axis units run in lockstep.
  a_axis_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ax_done_x == ax_done_y)
    else $error("axis units finished out of step");

  // The squaring unit reports only while the controller waits for it.
  a_sqr_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == ST_SQR))
    else $error("squaring unit finished outside its phase");

  // An issued goal marks the block as collecting.
  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && fire) |=> busy_q)
    else $error("collect started without setting busy");

  // A trigger restarts the slow-sample run.
  a_trig_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && trig) |=> (slow_cnt_q == 16'd0))
    else $error("slow count not cleared on trigger");

endmodule

`default_nettype wire
